FILE: rtl/core/oqpo_pkg.sv
// ----------------------------------------------------------------------------
// oqpo_pkg
// Shared constants for the ordered queue with positional ops.
// ----------------------------------------------------------------------------
package oqpo_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned OpW      = 3;
  localparam int unsigned PosW     = 5;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CountW   = 5;

  localparam logic [OpW-1:0] OP_PUSH    = 3'd0;
  localparam logic [OpW-1:0] OP_POP     = 3'd1;
  localparam logic [OpW-1:0] OP_RM_LAST = 3'd2;
  localparam logic [OpW-1:0] OP_RM_AT   = 3'd3;
  localparam logic [OpW-1:0] OP_INS_AFT = 3'd4;

  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd3;

endpackage

FILE: rtl/core/oqpo_ram.sv
// ----------------------------------------------------------------------------
// oqpo_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module oqpo_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/ordered_queue_positional_ops.sv
// ----------------------------------------------------------------------------
// ordered_queue_positional_ops
// Bounded ordered queue with push, pop, remove-last, remove-at, insert-after.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// request | in        | start_i / busy_o   | operation_i, value_i, position_i
// result  | out       | done_o (one cycle) | data_o, status_o, count_o
//
// Entries sit in one RAM with one read and one write port. A request that
// moves k entries takes one read-modify-write step per entry plus one step
// for the new value or the closing check, then the result beat; pop adds
// one head read before its steps. Remove-last, rejected requests and unused
// codes give the result in the cycle after acceptance. busy_o is high from
// the accepting edge through the result beat; the receiver cannot stall.
// Reset clears only the count and the control state.
module ordered_queue_positional_ops #(
  parameter int unsigned DEPTH = oqpo_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [oqpo_pkg::OpW-1:0]      operation_i,
  input  logic signed [oqpo_pkg::DataW-1:0] value_i,
  input  logic [oqpo_pkg::PosW-1:0]     position_i,
  output logic                          done_o,
  output logic signed [oqpo_pkg::DataW-1:0] data_o,
  output logic [oqpo_pkg::StatW-1:0]    status_o,
  output logic [oqpo_pkg::CountW-1:0]   count_o
);
  import oqpo_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DROP  = 3'd1; // shift down: read k+1, write k
  localparam logic [2:0] S_PLACE = 3'd2; // shift up: read k-1, write k
  localparam logic [2:0] S_POPRD = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [NW-1:0]      occ_q, occ_d;
  logic [AW-1:0]      k_q, k_d;     // slot being written next
  logic [AW-1:0]      stop_q, stop_d;
  logic signed [DataW-1:0] val_q, val_d, data_q, data_d;
  logic [StatW-1:0]   stat_q, stat_d;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [DataW-1:0]   wdata, rdata;

  oqpo_ram #(.Width(DataW), .Depth(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [NW-1:0] pos_n;
  logic          pos_bad;
  logic          full, empty;

  always_comb begin
    pos_n   = NW'(position_i);
    if (PosW > NW && (position_i >> NW) != '0) pos_bad = 1'b1;
    else pos_bad = (position_i == '0) || (pos_n > occ_q);
    full    = (occ_q >= NW'(DEPTH));
    empty   = (occ_q == '0);
  end

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    k_d     = k_q;
    stop_d  = stop_q;
    val_d   = val_q;
    data_d  = data_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = k_q;
    wdata   = val_q;
    raddr   = k_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d  = value_i;
          data_d = '0;
          stat_d = ST_OK;
          state_d = S_DONE;
          case (operation_i)
            OP_PUSH: begin
              if (full) stat_d = ST_FULL;
              else begin
                k_d = AW'(occ_q); stop_d = AW'(occ_q);
                occ_d = occ_q + 1'b1; state_d = S_PLACE;
              end
            end
            OP_POP: begin
              if (empty) stat_d = ST_EMPTY;
              else begin
                raddr = '0; state_d = S_POPRD;
              end
            end
            OP_RM_LAST: begin
              if (empty) stat_d = ST_EMPTY;
              else occ_d = occ_q - 1'b1;
            end
            OP_RM_AT: begin
              if (empty) stat_d = ST_EMPTY;
              else if (pos_bad) stat_d = ST_BADPOS;
              else begin
                k_d = AW'(pos_n - 1'b1); stop_d = AW'(occ_q - 1'b1);
                raddr = AW'(pos_n);
                occ_d = occ_q - 1'b1; state_d = S_DROP;
              end
            end
            OP_INS_AFT: begin
              if (empty) begin
                k_d = '0; stop_d = '0; occ_d = occ_q + 1'b1; state_d = S_PLACE;
              end else if (full) stat_d = ST_FULL;
              else if (pos_bad) stat_d = ST_BADPOS;
              else begin
                k_d = AW'(occ_q); stop_d = AW'(pos_n);
                occ_d = occ_q + 1'b1; state_d = S_PLACE;
              end
            end
            default: ;
          endcase
          if (state_d == S_PLACE && k_d != stop_d) begin
            raddr = k_d - 1'b1;
          end
        end
      end
      S_POPRD: begin
        data_d = rdata;
        k_d = '0; stop_d = AW'(occ_q - 1'b1);
        raddr = AW'(1);
        occ_d = occ_q - 1'b1;
        state_d = S_DROP;
      end
      S_DROP: begin
        // occ_q already holds new count; stop_q is the old last slot, now vacated
        if (k_q == stop_q) state_d = S_DONE;
        else begin
          we = 1'b1; waddr = k_q; wdata = rdata;
          k_d = k_q + 1'b1;
          if (k_d != stop_q) begin
            raddr = k_d + 1'b1;
          end
        end
      end
      S_PLACE: begin
        we = 1'b1; waddr = k_q;
        if (k_q == stop_q) begin
          wdata = val_q; state_d = S_DONE;
        end else begin
          wdata = rdata;
          k_d = k_q - 1'b1;
          if (k_d != stop_q) begin
            raddr = k_d - 1'b1;
          end
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    stop_q <= stop_d;
    val_q  <= val_d;
    data_q <= data_d;
    stat_q <= stat_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign data_o   = data_q;
  assign status_o = stat_q;
  assign count_o  = CountW'(occ_q);

endmodule

FILE: rtl/core/oqpo_checker.sv
// ----------------------------------------------------------------------------
// oqpo_checker
// Port-level checks for the ordered queue, bound to the top level.
// ----------------------------------------------------------------------------
module oqpo_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [oqpo_pkg::StatW-1:0]  status_o,
  input logic [oqpo_pkg::CountW-1:0] count_o,
  input logic signed [oqpo_pkg::DataW-1:0] data_o
);
  import oqpo_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept without busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o) else $error("done not single beat");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done outside busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> data_o == '0) else $error("data on error");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> $stable(count_o)) else $error("count moved while idle");

endmodule

bind ordered_queue_positional_ops oqpo_checker u_oqpo_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .status_o (status_o),
  .count_o  (count_o),
  .data_o   (data_o)
);
